FILE: rtl/ate_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ate_pkg
// Shared sizes, command codes and status codes of the array table engine.
// ----------------------------------------------------------------------------
package ate_pkg;

  localparam int DEPTH  = 128;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int IDX_W  = 7;
  localparam int STAT_W = 2;
  localparam int OCNT_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_LSEARCH = 3'd2,
    CMD_BSEARCH = 3'd3,
    CMD_READ    = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

endpackage

FILE: rtl/array_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_table_engine
// Bounded table of signed 32-bit entries with insert, delete, linear and
// binary search and indexed read, run by a small sequencer over one RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for one cycle with out_valid high, and the
// receiver cannot stall it. The entries sit in a RAM with one write port and
// one registered read port, and one comparator is reused for every probe:
// insert, unknown commands and out-of-range reads finish straight from idle,
// read fetches the one entry, linear search reads the entries in order until
// a match or the end of the table, binary search halves the range per probe,
// and delete runs the binary search, then moves each entry behind the removed
// one down by one place. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module array_table_engine (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ate_pkg::CMD_W-1:0]            in_cmd,
  input  logic signed [ate_pkg::DATA_W-1:0]    in_value,
  input  logic [ate_pkg::IDX_W-1:0]            in_index,
  output logic                                 out_valid,
  output logic [ate_pkg::STAT_W-1:0]           out_status,
  output logic [ate_pkg::IDX_W-1:0]            out_found_index,
  output logic signed [ate_pkg::DATA_W-1:0]    out_read_value,
  output logic [ate_pkg::OCNT_W-1:0]           out_count
);

  import ate_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIN_ADDR,
    S_LIN_CMP,
    S_BIN_ADDR,
    S_BIN_CMP,
    S_SHIFT_ADDR,
    S_SHIFT_WR,
    S_READ_DATA
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          fill_r, fill_nxt;
  logic [CNT_W-1:0]          ptr_r, ptr_nxt;
  logic [CNT_W-1:0]          lo_r, lo_nxt;
  logic [CNT_W-1:0]          hi_r, hi_nxt;
  logic [CNT_W-1:0]          mid;
  logic signed [DATA_W-1:0]  key_r, key_nxt;
  logic                      is_del_r, is_del_nxt;

  logic                      out_valid_r, out_valid_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic [IDX_W-1:0]          out_idx_r, out_idx_nxt;
  logic signed [DATA_W-1:0]  out_rval_r, out_rval_nxt;
  logic [CNT_W-1:0]          out_cnt_r, out_cnt_nxt;

  logic signed [DATA_W-1:0]  mem [DEPTH];
  logic [ADDR_W-1:0]         rd_addr;
  logic signed [DATA_W-1:0]  rdata_r;
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic signed [DATA_W-1:0]  wr_data;

  logic                      accept;
  logic                      cmp_eq;
  logic                      cmp_lt;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // shared comparator
  assign cmp_eq = (rdata_r == key_r);
  assign cmp_lt = (rdata_r < key_r);

  assign mid = lo_r + ((hi_r - lo_r - CNT_W'(1)) >> 1);

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    ptr_nxt        = ptr_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    key_nxt        = key_r;
    is_del_nxt     = is_del_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_rval_nxt   = out_rval_r;
    out_cnt_nxt    = out_cnt_r;
    rd_addr        = ptr_r[ADDR_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = fill_r[ADDR_W-1:0];
    wr_data        = key_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt      = in_value;
          ptr_nxt      = '0;
          lo_nxt       = '0;
          hi_nxt       = fill_r;
          out_idx_nxt  = '0;
          out_rval_nxt = '0;
          out_cnt_nxt  = fill_r;
          case (cmd_t'(in_cmd))
            CMD_INSERT: begin
              out_valid_nxt = 1'b1;
              if (fill_r >= CNT_W'(DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                wr_en          = 1'b1;
                wr_data        = in_value;
                fill_nxt       = fill_r + CNT_W'(1);
                out_status_nxt = ST_OK;
                out_idx_nxt    = IDX_W'(fill_r);
                out_cnt_nxt    = fill_r + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              is_del_nxt = 1'b1;
              state_nxt  = S_BIN_ADDR;
            end
            CMD_BSEARCH: begin
              is_del_nxt = 1'b0;
              state_nxt  = S_BIN_ADDR;
            end
            CMD_LSEARCH: begin
              state_nxt = S_LIN_ADDR;
            end
            CMD_READ: begin
              if (CNT_W'(in_index) < fill_r) begin
                rd_addr   = ADDR_W'(in_index);
                ptr_nxt   = CNT_W'(in_index);
                state_nxt = S_READ_DATA;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_RANGE;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_RANGE;
            end
          endcase
        end
      end
      S_LIN_ADDR: begin
        if (ptr_r >= fill_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_LIN_CMP;
        end
      end
      S_LIN_CMP: begin
        if (cmp_eq) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_idx_nxt    = IDX_W'(ptr_r);
          state_nxt      = S_IDLE;
        end else begin
          ptr_nxt   = ptr_r + CNT_W'(1);
          state_nxt = S_LIN_ADDR;
        end
      end
      S_BIN_ADDR: begin
        if (lo_r >= hi_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_IDLE;
        end else begin
          rd_addr   = mid[ADDR_W-1:0];
          ptr_nxt   = mid;
          state_nxt = S_BIN_CMP;
        end
      end
      S_BIN_CMP: begin
        if (cmp_eq) begin
          out_idx_nxt = IDX_W'(ptr_r);
          if (is_del_r) begin
            state_nxt = S_SHIFT_ADDR;
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            state_nxt      = S_IDLE;
          end
        end else begin
          if (cmp_lt) begin
            lo_nxt = ptr_r + CNT_W'(1);
          end else begin
            hi_nxt = ptr_r;
          end
          state_nxt = S_BIN_ADDR;
        end
      end
      S_SHIFT_ADDR: begin
        if (ptr_r + CNT_W'(1) >= fill_r) begin
          fill_nxt       = fill_r - CNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_cnt_nxt    = fill_r - CNT_W'(1);
          state_nxt      = S_IDLE;
        end else begin
          rd_addr   = ADDR_W'(ptr_r + CNT_W'(1));
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        wr_en     = 1'b1;
        wr_addr   = ptr_r[ADDR_W-1:0];
        wr_data   = rdata_r;
        ptr_nxt   = ptr_r + CNT_W'(1);
        state_nxt = S_SHIFT_ADDR;
      end
      S_READ_DATA: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_idx_nxt    = IDX_W'(ptr_r);
        out_rval_nxt   = rdata_r;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r        <= ptr_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    key_r        <= key_nxt;
    is_del_r     <= is_del_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_rval_r   <= out_rval_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_idx_r;
  assign out_read_value  = out_rval_r;
  assign out_count       = OCNT_W'(out_cnt_r);

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill count above capacity");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (fill_r != $past(fill_r)) |->
      (fill_r == $past(fill_r) + CNT_W'(1)) || (fill_r == $past(fill_r) - CNT_W'(1)))
    else $error("fill count moved by more than one");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result shown while sequencer busy");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_FULL) |-> (out_cnt_r == CNT_W'(DEPTH)))
    else $error("full reported below capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> (out_idx_r == '0) && (out_rval_r == '0))
    else $error("failed request carries nonzero payload");

endmodule
